@@ hdl/mbt_pkg.sv @@
// ----------------------------------------------------------------------------
// mbt_pkg: shared constants for the modular binomial table
// Word width, modulus, operation codes and status codes.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int unsigned PW = 30;
  localparam logic [PW-1:0] PRIME_MODULUS = 30'd1000000007;
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned CNTW = $clog2(PW);

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BEYOND    = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

endpackage

@@ hdl/mbt_mulmod.sv @@
// ----------------------------------------------------------------------------
// mbt_mulmod: bit-serial modular multiplier
// Computes a*b mod p, one bit of b per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mbt_mulmod (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mbt_pkg::PW-1:0]   a,
  input  logic [mbt_pkg::PW-1:0]   b,
  output logic                     done,
  output logic [mbt_pkg::PW-1:0]   result
);

  localparam int unsigned PW = mbt_pkg::PW;
  localparam int unsigned CNTW = mbt_pkg::CNTW;
  localparam logic [PW+1:0] PX = (PW+2)'(mbt_pkg::PRIME_MODULUS);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   acc;
  logic [PW-1:0]   ar;
  logic [PW-1:0]   br;
  logic [PW+1:0]   sum;
  logic [PW+1:0]   red1;
  logic [PW+1:0]   red2;

  // Accumulator stays below p, so 2*acc + a stays below 3p.
  always_comb begin
    sum  = {1'b0, acc, 1'b0} + (br[PW-1] ? {2'b00, ar} : '0);
    red1 = (sum >= PX) ? sum - PX : sum;
    red2 = (red1 >= PX) ? red1 - PX : red1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ar  <= a;
      br  <= b;
      cnt <= CNTW'(PW - 1);
    end else if (busy) begin
      acc <= red2[PW-1:0];
      br  <= {br[PW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign result = acc;

endmodule

@@ hdl/mbt_div.sv @@
// ----------------------------------------------------------------------------
// mbt_div: restoring divider of the modulus by a table index
// Gives p div d and p mod d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbt_div #(
  parameter int unsigned IW = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [IW-1:0]            divisor,
  output logic                     done,
  output logic [mbt_pkg::PW-1:0]   quot,
  output logic [IW-1:0]            rem
);

  localparam int unsigned PW = mbt_pkg::PW;
  localparam int unsigned CNTW = mbt_pkg::CNTW;
  localparam logic [PW-1:0] PV = mbt_pkg::PRIME_MODULUS;

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [IW-1:0]   dr;
  logic [IW:0]     rem_r;
  logic [IW:0]     sh;
  logic            ge;

  always_comb begin
    sh = {rem_r[IW-1:0], PV[cnt]};
    ge = sh >= {1'b0, dr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quot  <= '0;
      dr    <= divisor;
      cnt   <= CNTW'(PW - 1);
    end else if (busy) begin
      rem_r <= ge ? sh - {1'b0, dr} : sh;
      quot  <= {quot[PW-2:0], ge};
      cnt   <= cnt - 1'b1;
    end
  end

  assign rem = rem_r[IW-1:0];

endmodule

@@ hdl/modular_binomial_table.sv @@
// ----------------------------------------------------------------------------
// modular_binomial_table: binomial coefficients modulo a prime from tables
// Builds factorial, inverse and inverse factorial tables, answers C(n,r) mod p.
// ----------------------------------------------------------------------------
// Usage: one input beat (opcode, count_n, choose_r) gives one output beat
// (value, status). Both channels use valid/stall; a beat moves when valid is
// high and stall is low. in_stall is high from the accepted beat until the
// result has been loaded into the output register.
// A query whose answer needs no table read goes straight to the done state when
// its beat is taken and is loaded into the output register from there; no new
// beat is taken before that load. A table query reads the tables once and runs
// two modular multiplies in series on the shared bit-serial multiplier before
// its result is loaded into the output register. A build of top index N >= 2
// runs, for each entry past the first two, the divider and three multiplies in
// series plus a read and a write. Errors and trivial cases are settled in the
// accept cycle. Reset empties the output register and marks the tables as not
// built; the table memories themselves are not cleared. When the receiver
// stalls, the finished result waits in the output register; a new beat can
// still be taken, and its result waits in the done state until the load.
// ----------------------------------------------------------------------------
module modular_binomial_table #(
  parameter int unsigned TABLE_ENTRIES = mbt_pkg::TABLE_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic signed [12:0]       count_n,
  input  logic signed [12:0]       choose_r,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [mbt_pkg::PW-1:0]   value,
  output logic [1:0]               status
);

  localparam int unsigned PW = mbt_pkg::PW;
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = ($clog2(TABLE_ENTRIES + 1) > 13) ?
                               $clog2(TABLE_ENTRIES + 1) : 13;
  localparam logic [PW-1:0] P = mbt_pkg::PRIME_MODULUS;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_INIT = 12'b000000000010,
    S_DIV  = 12'b000000000100,
    S_RD   = 12'b000000001000,
    S_M1   = 12'b000000010000,
    S_M2   = 12'b000000100000,
    S_M3   = 12'b000001000000,
    S_WR   = 12'b000010000000,
    S_QRD  = 12'b000100000000,
    S_QM1  = 12'b001000000000,
    S_QM2  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t state;

  logic [PW-1:0] fac_mem  [TABLE_ENTRIES];
  logic [PW-1:0] inv_mem  [TABLE_ENTRIES];
  logic [PW-1:0] finv_mem [TABLE_ENTRIES];

  logic [PW-1:0] fac_rd;
  logic [PW-1:0] inv_rd;
  logic [PW-1:0] finv_rd0;
  logic [PW-1:0] finv_rd1;

  logic [IW-1:0] idx;
  logic [IW-1:0] top;
  logic [IW-1:0] built_top;
  logic          tables_valid;
  logic [IW-1:0] qn;
  logic [IW-1:0] qr;
  logic [IW-1:0] qd;
  logic [PW-1:0] fac_prev;
  logic [PW-1:0] finv_prev;
  logic [PW-1:0] inv_i;
  logic [PW-1:0] t_reg;
  logic          launched;
  logic [PW-1:0] res_value;
  logic [1:0]    res_status;

  logic          mm_start;
  logic [PW-1:0] mm_a;
  logic [PW-1:0] mm_b;
  logic          mm_done;
  logic [PW-1:0] mm_res;
  logic          dv_start;
  logic          dv_done;
  logic [PW-1:0] dv_quot;
  logic [IW-1:0] dv_rem;

  logic          wr_en;
  logic [PW-1:0] wr_fac;
  logic [PW-1:0] wr_inv;
  logic [PW-1:0] wr_finv;

  logic          accept;
  logic          out_load;
  logic [CW-1:0] n_u;
  logic [CW-1:0] r_u;
  logic [CW-1:0] d_u;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign n_u = CW'(count_n[11:0]);
  assign r_u = CW'(choose_r[11:0]);
  assign d_u = n_u - r_u;

  mbt_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .done   (mm_done),
    .result (mm_res)
  );

  mbt_div #(.IW(IW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (dv_start),
    .divisor (idx),
    .done    (dv_done),
    .quot    (dv_quot),
    .rem     (dv_rem)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mm_start = 1'b0;
    mm_a     = fac_rd;
    mm_b     = t_reg;
    dv_start = (state == S_DIV) && !launched;
    case (state)
      S_M1: begin
        mm_start = !launched;
        mm_a     = inv_rd;
        mm_b     = dv_quot;
      end
      S_M2: begin
        mm_start = !launched;
        mm_a     = fac_prev;
        mm_b     = PW'(idx);
      end
      S_M3: begin
        mm_start = !launched;
        mm_a     = finv_prev;
        mm_b     = inv_i;
      end
      S_QM1: begin
        mm_start = !launched;
        mm_a     = finv_rd0;
        mm_b     = finv_rd1;
      end
      S_QM2: begin
        mm_start = !launched;
        mm_a     = fac_rd;
        mm_b     = t_reg;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = (state == S_INIT) || (state == S_WR);
    wr_fac  = fac_prev;
    wr_inv  = inv_i;
    wr_finv = finv_prev;
    if (state == S_INIT) begin
      wr_fac  = PW'(1);
      wr_inv  = (idx == '0) ? '0 : PW'(1);
      wr_finv = PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fac_mem[idx]  <= wr_fac;
      inv_mem[idx]  <= wr_inv;
      finv_mem[idx] <= wr_finv;
    end
    fac_rd   <= fac_mem[qn];
    inv_rd   <= inv_mem[dv_rem];
    finv_rd0 <= finv_mem[qr];
    finv_rd1 <= finv_mem[qd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launched     <= 1'b0;
      tables_valid <= 1'b0;
      built_top    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (mm_start || dv_start) begin
        launched <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == mbt_pkg::OP_BUILD) begin
              res_value <= '0;
              if (count_n[12] || n_u >= CW'(TABLE_ENTRIES)) begin
                res_status <= mbt_pkg::ST_NOT_BUILT;
                state      <= S_DONE;
              end else begin
                res_status <= mbt_pkg::ST_OK;
                top        <= n_u[IW-1:0];
                idx        <= '0;
                state      <= S_INIT;
              end
            end else if (!tables_valid) begin
              res_value  <= '0;
              res_status <= mbt_pkg::ST_NOT_BUILT;
              state      <= S_DONE;
            end else if (count_n < choose_r || count_n[12] || choose_r[12]) begin
              res_value  <= '0;
              res_status <= mbt_pkg::ST_OK;
              state      <= S_DONE;
            end else if (count_n == choose_r || choose_r == '0) begin
              res_value  <= PW'(1);
              res_status <= mbt_pkg::ST_OK;
              state      <= S_DONE;
            end else if (n_u > CW'(built_top)) begin
              res_value  <= '0;
              res_status <= mbt_pkg::ST_BEYOND;
              state      <= S_DONE;
            end else begin
              res_status <= mbt_pkg::ST_OK;
              qn         <= n_u[IW-1:0];
              qr         <= r_u[IW-1:0];
              qd         <= d_u[IW-1:0];
              state      <= S_QRD;
            end
          end
        end
        S_INIT: begin
          fac_prev  <= PW'(1);
          finv_prev <= PW'(1);
          if (idx == top) begin
            built_top    <= top;
            tables_valid <= 1'b1;
            state        <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= (idx == '0) ? S_INIT : S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            launched <= 1'b0;
            state    <= S_RD;
          end
        end
        S_RD: begin
          state <= S_M1;
        end
        S_M1: begin
          if (mm_done) begin
            launched <= 1'b0;
            inv_i    <= (mm_res == '0) ? '0 : P - mm_res;
            state    <= S_M2;
          end
        end
        S_M2: begin
          if (mm_done) begin
            launched <= 1'b0;
            fac_prev <= mm_res;
            state    <= S_M3;
          end
        end
        S_M3: begin
          if (mm_done) begin
            launched  <= 1'b0;
            finv_prev <= mm_res;
            state     <= S_WR;
          end
        end
        S_WR: begin
          if (idx == top) begin
            built_top    <= top;
            tables_valid <= 1'b1;
            state        <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DIV;
          end
        end
        S_QRD: begin
          state <= S_QM1;
        end
        S_QM1: begin
          if (mm_done) begin
            launched <= 1'b0;
            t_reg    <= mm_res;
            state    <= S_QM2;
          end
        end
        S_QM2: begin
          if (mm_done) begin
            launched  <= 1'b0;
            res_value <= mm_res;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value  <= res_value;
      status <= res_status;
    end
  end

endmodule

@@ hdl/mbt_checker.sv @@
// ----------------------------------------------------------------------------
// mbt_checker: port-level checks for the modular binomial table
// Watches both channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module mbt_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [mbt_pkg::PW-1:0]   value,
  input logic [1:0]               status
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("output beat changed while stalled");

  // An accepted beat keeps the input closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  // Error results carry a zero value and no unused status code.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mbt_pkg::ST_OK |-> value == '0 &&
    (status == mbt_pkg::ST_BEYOND || status == mbt_pkg::ST_NOT_BUILT))
    else $error("bad error result");

  // Reset leaves the output channel empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modular_binomial_table mbt_checker u_mbt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .status    (status)
);

@@ sim/modular_binomial_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_binomial_table_tb: self-checking bench for the modular binomial table
// A directed table of builds and queries, then random traffic, is sent with
// random gaps and output stalls. Each result is compared with the value and
// status typed into its table row, or else with a local factorial-table model.
// ----------------------------------------------------------------------------
module modular_binomial_table_tb;

  localparam int unsigned PW = mbt_pkg::PW;
  localparam longint unsigned MOD = mbt_pkg::PRIME_MODULUS;
  localparam int unsigned IDLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_ITEMS = 480;

  typedef struct {
    logic             op;
    int               n;
    int               r;
    bit               typed;
    logic [PW-1:0]    value;
    logic [1:0]       status;
  } stim_row_t;

  typedef struct {
    logic [PW-1:0]    value;
    logic [1:0]       status;
  } binom_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic signed [12:0] count_n;
  logic signed [12:0] choose_r;
  logic               out_valid;
  logic               out_stall;
  logic [PW-1:0]      value;
  logic [1:0]         status;

  modular_binomial_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .count_n(count_n), .choose_r(choose_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .status(status)
  );

  // Local copy of the tables and of the built state.
  longint unsigned fact_tab [mbt_pkg::TABLE_ENTRIES];
  longint unsigned inv_tab [mbt_pkg::TABLE_ENTRIES];
  longint unsigned inv_fact_tab [mbt_pkg::TABLE_ENTRIES];
  int              model_top;
  bit              model_built;

  binom_result_t   results_due [$];
  int              mismatches;
  int unsigned     idle_cycles;
  bit              quiet_out;
  int              stall_left;

  stim_row_t plan [] = '{
    '{mbt_pkg::OP_QUERY, 5, 2, 1'b1, 30'd0, mbt_pkg::ST_NOT_BUILT},
    '{mbt_pkg::OP_BUILD, -1, 0, 1'b1, 30'd0, mbt_pkg::ST_NOT_BUILT},
    '{mbt_pkg::OP_BUILD, -4096, 4095, 1'b1, 30'd0, mbt_pkg::ST_NOT_BUILT},
    '{mbt_pkg::OP_QUERY, 3, 1, 1'b1, 30'd0, mbt_pkg::ST_NOT_BUILT},
    '{mbt_pkg::OP_BUILD, 0, 0, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 0, 0, 1'b1, 30'd1, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 1, 0, 1'b1, 30'd1, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 2, 1, 1'b1, 30'd0, mbt_pkg::ST_BEYOND},
    '{mbt_pkg::OP_QUERY, 4095, 4095, 1'b1, 30'd1, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, -4096, -4096, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 3, 5, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_BUILD, 10, -4096, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 10, 3, 1'b1, 30'd120, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 10, 5, 1'b0, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 11, 2, 1'b1, 30'd0, mbt_pkg::ST_BEYOND},
    '{mbt_pkg::OP_BUILD, 4095, 0, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 4095, 1, 1'b0, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 4095, 2048, 1'b0, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 4000, 1234, 1'b0, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 4095, -1, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_BUILD, 1, 0, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 2, 1, 1'b1, 30'd0, mbt_pkg::ST_BEYOND},
    '{mbt_pkg::OP_QUERY, 1, 1, 1'b1, 30'd1, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_BUILD, 5, 0, 1'b1, 30'd0, mbt_pkg::ST_OK},
    '{mbt_pkg::OP_QUERY, 5, 2, 1'b1, 30'd10, mbt_pkg::ST_OK}
  };

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
    return (a * b) % MOD;
  endfunction

  function automatic void fill_tables(int top);
    longint unsigned x;
    for (int i = 0; i <= top; i++) begin
      if (i <= 1) begin
        fact_tab[i] = 1;
        inv_tab[i] = (i == 0) ? 0 : 1;
        inv_fact_tab[i] = 1;
      end else begin
        fact_tab[i] = mod_mul(fact_tab[i-1], i);
        x = mod_mul(inv_tab[MOD % i], MOD / i);
        inv_tab[i] = (MOD - x) % MOD;
        inv_fact_tab[i] = mod_mul(inv_fact_tab[i-1], inv_tab[i]);
      end
    end
  endfunction

  // Applies one item to the local state and returns the result it causes.
  function automatic binom_result_t binom_predict(logic op, int n, int r);
    binom_result_t res;
    res.value = '0;
    res.status = mbt_pkg::ST_OK;
    if (op == mbt_pkg::OP_BUILD) begin
      if (n < 0 || n >= int'(mbt_pkg::TABLE_ENTRIES)) begin
        res.status = mbt_pkg::ST_NOT_BUILT;
      end else begin
        fill_tables(n);
        model_top = n;
        model_built = 1'b1;
      end
    end else if (!model_built) begin
      res.status = mbt_pkg::ST_NOT_BUILT;
    end else if (n < r || n < 0 || r < 0) begin
      res.value = '0;
    end else if (n == r || r == 0) begin
      res.value = 1;
    end else if (n > model_top) begin
      res.status = mbt_pkg::ST_BEYOND;
    end else begin
      res.value = PW'(mod_mul(fact_tab[n], mod_mul(inv_fact_tab[r], inv_fact_tab[n-r])));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one beat, waits for it to be taken and queues its result.
  task automatic send_beat(stim_row_t row);
    binom_result_t res;
    int gap;
    in_valid <= 1'b1;
    opcode <= row.op;
    count_n <= 13'(row.n);
    choose_r <= 13'(row.r);
    do @(posedge clk); while (in_stall);
    res = binom_predict(row.op, row.n, row.r);
    if (row.typed) begin
      res.value = row.value;
      res.status = row.status;
    end
    results_due.push_back(res);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int kind;
    row.typed = 1'b0;
    row.value = '0;
    row.status = mbt_pkg::ST_OK;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      row.op = mbt_pkg::OP_BUILD;
      row.n = $urandom_range(0, 60);
      row.r = $urandom_range(0, 8191) - 4096;
    end else if (kind < 7) begin
      // Out-of-range build size.
      row.op = mbt_pkg::OP_BUILD;
      row.n = -int'($urandom_range(1, 4096));
      row.r = $urandom_range(0, 8191) - 4096;
    end else if (kind < 80) begin
      row.op = mbt_pkg::OP_QUERY;
      row.n = $urandom_range(0, model_top);
      row.r = $urandom_range(0, row.n);
    end else begin
      row.op = mbt_pkg::OP_QUERY;
      row.n = $urandom_range(0, 8191) - 4096;
      row.r = $urandom_range(0, 8191) - 4096;
    end
    return row;
  endfunction

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Output side: check each beat and stall at random.
  always @(posedge clk) begin
    binom_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat", value, -1);
        end else begin
          want = results_due.pop_front();
          if (value !== want.value) report_mismatch("value", value, want.value);
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet_out && $urandom_range(0, 9) < 3) begin
        stall_left <= pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = mbt_pkg::OP_BUILD;
    count_n = '0;
    choose_r = '0;
    out_stall = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    quiet_out = 1'b0;
    stall_left = 0;
    model_top = 0;
    model_built = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i]);
    in_valid <= 1'b0;
    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // A stretch with no output stalls now and then.
      if (k % 100 == 0) quiet_out = ~quiet_out;
      send_beat(random_row());
    end
    in_valid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
